// ===== rtl/core/wpm_pkg.sv =====
// wpm_pkg: shared types and constants of the wildcard pattern matcher
package wpm_pkg;

   // request codes as they arrive on req_type
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_BEGIN  = 2'd2,
      CMD_TEXT   = 2'd3
   } cmd_type;

   localparam logic [7:0] SYM_STAR  = 8'h2A;
   localparam logic [7:0] SYM_QUEST = 8'h3F;

   // decoupling queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // classified transaction handed from front to back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] symbol;
      logic       is_star;
      logic       is_quest;
      logic       has_rsp;
   } item_type;

endpackage

// ===== rtl/core/wpm_front.sv =====
// wpm_front: input register that accepts and classifies request transactions
module wpm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_symbol,
   output logic              item_valid,
   output wpm_pkg::item_type item,
   input  logic              item_ready
);
   import wpm_pkg::*;

   logic     fv_ff, fv_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_stall  = fv_ff && !item_ready;
   assign load       = req_valid && !req_stall;
   assign item_valid = fv_ff;
   assign item       = item_ff;

   // decode the request
   always_comb begin
      item_in.cmd      = cmd_type'(req_type);
      item_in.symbol   = req_symbol;
      item_in.is_star  = (req_symbol == SYM_STAR);
      item_in.is_quest = (req_symbol == SYM_QUEST);
      case (item_in.cmd)
         CMD_BEGIN: item_in.has_rsp = 1'b1;
         CMD_TEXT:  item_in.has_rsp = 1'b1;
         default:   item_in.has_rsp = 1'b0;
      endcase
   end

   always_comb begin
      if (!fv_ff || item_ready) begin
         fv_in = req_valid;
      end else begin
         fv_in = fv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/core/wpm_queue.sv =====
// wpm_queue: short fifo between front and back
module wpm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  wpm_pkg::item_type in_item,
   output logic              in_ready,
   output logic              out_valid,
   output wpm_pkg::item_type out_item,
   input  logic              out_ready
);
   import wpm_pkg::*;

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff < QCNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/core/wpm_back.sv =====
// wpm_back: pattern cells, match row update and result register
module wpm_back #(
   parameter int MAX_PATTERN = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  wpm_pkg::item_type item,
   output logic              item_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_matched,
   output logic              rsp_overflowed
);
   import wpm_pkg::*;

   localparam int N   = MAX_PATTERN + 1;
   localparam int LVL = $clog2(N);

   // pattern cells
   logic [7:0]             sym_ff [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] active_ff, active_in;
   logic [MAX_PATTERN-1:0] star_ff, star_in;
   logic [MAX_PATTERN-1:0] quest_ff, quest_in;
   logic [MAX_PATTERN-1:0] wr_en, hit;
   logic                   ovf_ff, ovf_in;
   logic                   full;

   // match row and its scan
   logic [N-1:0] row_ff, row_in;
   logic [N-1:0] last_oh;
   logic [N-1:0] adv_g, adv_p, rst_g, rst_p;
   logic [N-1:0] sg, sp;
   logic         do_restart;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic matched_ff, ovf_out_ff;
   logic pop;

   assign item_ready     = !rsp_valid_ff || !rsp_stall;
   assign pop            = item_valid && item_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_matched    = matched_ff;
   assign rsp_overflowed = ovf_out_ff;

   // one-hot of the current length; its low part is the next free cell
   assign last_oh = {active_ff, 1'b1} & ~{1'b0, active_ff};
   assign full    = active_ff[MAX_PATTERN-1];

   always_comb begin
      wr_en     = '0;
      active_in = active_ff;
      ovf_in    = ovf_ff;
      case (item.cmd)
         CMD_CLEAR: begin
            active_in = '0;
            ovf_in    = 1'b0;
         end
         CMD_APPEND: begin
            wr_en     = last_oh[MAX_PATTERN-1:0];
            active_in = active_ff | last_oh[MAX_PATTERN-1:0];
            ovf_in    = ovf_ff | full;
         end
         default: begin
            wr_en = '0;
         end
      endcase
      if (!pop) begin
         wr_en     = '0;
         active_in = active_ff;
         ovf_in    = ovf_ff;
      end
   end

   assign star_in  = (star_ff & ~wr_en) | (wr_en & {MAX_PATTERN{item.is_star}});
   assign quest_in = (quest_ff & ~wr_en) | (wr_en & {MAX_PATTERN{item.is_quest}});

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         hit[k] = quest_ff[k] | (sym_ff[k] == item.symbol);
      end
   end

   // per entry generate and propagate terms
   assign adv_p = {active_ff & star_ff, 1'b0};
   assign adv_g = {active_ff, 1'b0}
                & (({star_ff, 1'b0} & row_ff)
                 | (~{star_ff, 1'b0} & {hit, 1'b0} & {row_ff[N-2:0], 1'b0}));
   assign rst_g = N'(1);
   assign rst_p = {active_in & star_in, 1'b0};
   assign do_restart = (item.cmd != CMD_TEXT);

   // log-depth segmented or-scan along runs of stars
   always_comb begin
      sg = do_restart ? rst_g : adv_g;
      sp = do_restart ? rst_p : adv_p;
      for (int l = 0; l < LVL; l++) begin
         sg = sg | (sp & (sg << (1 << l)));
         sp = sp & (sp << (1 << l));
      end
   end

   always_comb begin
      if (pop && !(item.cmd == CMD_APPEND && full)) begin
         row_in = sg;
      end else begin
         row_in = row_ff;
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = item.has_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         ovf_ff       <= 1'b0;
         row_ff       <= N'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         ovf_ff       <= ovf_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      star_ff  <= star_in;
      quest_ff <= quest_in;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (wr_en[k]) begin
            sym_ff[k] <= item.symbol;
         end
      end
      if (pop && item.has_rsp) begin
         matched_ff <= |(sg & last_oh);
         ovf_out_ff <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   a_row_above_length_zero: assert property (@(posedge clock) disable iff (reset)
      (row_ff & ~{active_ff, 1'b1}) == '0)
      else $error("match row set above pattern length");

   a_active_thermometer: assert property (@(posedge clock) disable iff (reset)
      ((active_ff + 1'b1) & active_ff) == '0)
      else $error("pattern cells not filled from the bottom");

   a_overflow_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(pop && item.cmd == CMD_APPEND && full))
      else $error("overflow set without an append to a full pattern");

   a_full_append_keeps_row: assert property (@(posedge clock) disable iff (reset)
      (pop && item.cmd == CMD_APPEND && full) |=> $stable(row_ff) && $stable(active_ff))
      else $error("dropped append changed the pattern or match row");
`endif

endmodule

// ===== rtl/core/wildcard_pattern_matcher.sv =====
// wildcard_pattern_matcher: streaming '*' / '?' wildcard matcher, top level
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   req     | in        | req_valid / req_stall  | req_type[1:0], req_symbol[7:0]
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_matched, rsp_overflowed
//
// one transaction per cycle sustained without rsp_stall; every match row entry updates in
// the same cycle, with a log2(MAX_PATTERN+1) level or-scan carrying runs of stars
// an accepted req passes the front register, the queue, then the result register to rsp
// clear and append produce no rsp transaction; begin and text produce one
// reset clears fill mask and queue, sets match row to entry 0; cells need no clearing pass
// rsp_stall backs up the result register, then the queue, then req_stall
module wildcard_pattern_matcher #(
   parameter int MAX_PATTERN = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_overflowed
);
   import wpm_pkg::*;

   // front to queue
   item_type front_item;
   logic     front_valid;
   logic     front_ready;

   // queue to back
   item_type back_item;
   logic     back_valid;
   logic     back_ready;

   // front: register and decode each request transaction
   wpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_symbol (req_symbol),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   // queue: lets the front keep accepting while the result side is stalled
   wpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_item  (back_item),
      .out_ready (back_ready)
   );

   // back: pattern cells, match row and the result register
   wpm_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (back_valid),
      .item           (back_item),
      .item_ready     (back_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_matched    (rsp_matched),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule
